// ===== design/i2cdf_pkg.sv =====
// Shared types and constants for the I2C ID message deframer.
package i2cdf_pkg;

	// Default payload capacity of one message, in bytes
	localparam int MSG_CAPACITY_DEF = 256;

	// Framing characters
	localparam logic [7:0] CHR_NUL = 8'h00;
	localparam logic [7:0] CHR_LF  = 8'h0A;
	localparam logic [7:0] CHR_CR  = 8'h0D;
	localparam logic [7:0] CHR_SP  = 8'h20;
	localparam logic [7:0] CHR_TAB = 8'h09;
	localparam logic [7:0] CHR_FF  = 8'h0C;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	// Longest ID field before a carriage return must show up
	localparam logic [2:0] ID_MAX_CHARS = 3'd6;

	// Receiver mode
	typedef enum logic [2:0] {
		MODE_UNSYNC = 3'b001,
		MODE_CMD    = 3'b010,
		MODE_DATA   = 3'b100
	} mode_t;

	// ID parse phase (atoi style)
	typedef enum logic [2:0] {
		PH_SPACE  = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	// Running ID parse state
	typedef struct packed {
		phase_t      phase;
		logic        negative;
		logic [15:0] acc;
	} id_state_t;

	// One result item
	typedef struct packed {
		logic               data_valid;
		logic [7:0]         data_byte;
		logic [7:0]         byte_index;
		logic               message_done;
		logic signed [15:0] message_id;
		logic               overflow;
		logic               sync_lost;
	} res_t;

endpackage

// ===== design/i2cdf_id_parse.sv =====
// One step of atoi-style decimal ID parsing, 16-bit wraparound.
module i2cdf_id_parse (
	input  i2cdf_pkg::id_state_t cur,
	input  logic [7:0]           chr,
	output i2cdf_pkg::id_state_t nxt
);

	logic is_digit;
	logic is_space;
	logic is_sign;

	assign is_digit = (chr >= i2cdf_pkg::CHR_ZERO) && (chr <= i2cdf_pkg::CHR_NINE);
	assign is_space = (chr == i2cdf_pkg::CHR_SP) ||
		((chr >= i2cdf_pkg::CHR_TAB) && (chr <= i2cdf_pkg::CHR_FF));
	assign is_sign  = (chr == i2cdf_pkg::CHR_PLUS) || (chr == i2cdf_pkg::CHR_MINUS);

	// Whitespace/sign phase, then digit accumulation (acc*10 + digit)
	always_comb begin
		nxt = cur;
		case (cur.phase)
			i2cdf_pkg::PH_SPACE: begin
				if (is_space) begin
					nxt = cur;
				end else if (is_sign) begin
					nxt.negative = (chr == i2cdf_pkg::CHR_MINUS);
					nxt.phase    = i2cdf_pkg::PH_DIGITS;
				end else if (is_digit) begin
					nxt.phase = i2cdf_pkg::PH_DIGITS;
					nxt.acc   = {cur.acc[12:0], 3'b000} + {cur.acc[14:0], 1'b0} +
						{12'd0, chr[3:0]};
				end else begin
					nxt.phase = i2cdf_pkg::PH_DONE;
				end
			end
			i2cdf_pkg::PH_DIGITS: begin
				if (is_digit) begin
					nxt.acc = {cur.acc[12:0], 3'b000} + {cur.acc[14:0], 1'b0} +
						{12'd0, chr[3:0]};
				end else begin
					nxt.phase = i2cdf_pkg::PH_DONE;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== design/i2cdf_frame.sv =====
// Framing state machine: ID field, payload counting, resync and result forming.
module i2cdf_frame #(
	parameter int MSG_CAPACITY = i2cdf_pkg::MSG_CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       chr,
	input  logic             eot,
	output logic             emit,
	output i2cdf_pkg::res_t  res
);

	localparam int CNT_W = $clog2(MSG_CAPACITY + 1);

	i2cdf_pkg::mode_t     mode_q, mode_n;
	logic                 skip_q, skip_n;
	logic [2:0]           idcnt_q, idcnt_n;
	i2cdf_pkg::id_state_t id_q, id_n, id_fed;
	logic [15:0]          held_q, held_n;
	logic [CNT_W-1:0]     cnt_q, cnt_n;
	logic                 ovf_q, ovf_n;
	logic [CNT_W+7:0]     cnt_ext;
	logic                 term;
	logic                 long_id;

	localparam i2cdf_pkg::id_state_t ID_CLEAR = '{
		phase: i2cdf_pkg::PH_SPACE, negative: 1'b0, acc: 16'd0};

	i2cdf_id_parse u_id_parse (
		.cur (id_q),
		.chr (chr),
		.nxt (id_fed)
	);

	assign cnt_ext = {8'd0, cnt_q};

	// Next state and result for the byte at hand
	always_comb begin
		mode_n  = mode_q;
		skip_n  = skip_q;
		idcnt_n = idcnt_q;
		id_n    = id_q;
		held_n  = held_q;
		cnt_n   = cnt_q;
		ovf_n   = ovf_q;
		res     = '0;
		emit    = 1'b0;
		term    = 1'b0;
		long_id = 1'b0;
		if (skip_q) begin
			// drop the rest of the transfer
			if (eot) begin
				skip_n = 1'b0;
			end
		end else begin
			case (mode_q)
				i2cdf_pkg::MODE_CMD: begin
					if (chr == i2cdf_pkg::CHR_CR) begin
						held_n = id_q.negative ? (~id_q.acc + 16'd1) : id_q.acc;
						mode_n = i2cdf_pkg::MODE_DATA;
						cnt_n  = '0;
						ovf_n  = 1'b0;
					end else if (idcnt_q >= i2cdf_pkg::ID_MAX_CHARS) begin
						// ID too long
						long_id       = 1'b1;
						mode_n        = i2cdf_pkg::MODE_UNSYNC;
						id_n          = ID_CLEAR;
						idcnt_n       = 3'd0;
						cnt_n         = '0;
						skip_n        = !eot;
						res.sync_lost = 1'b1;
						res.overflow  = ovf_q;
						emit          = 1'b1;
					end else begin
						id_n    = id_fed;
						idcnt_n = idcnt_q + 3'd1;
					end
				end
				i2cdf_pkg::MODE_DATA: begin
					if (chr == i2cdf_pkg::CHR_NUL) begin
						res.byte_index   = cnt_ext[7:0];
						res.message_done = 1'b1;
						res.message_id   = held_q;
						res.overflow     = ovf_q;
						emit             = 1'b1;
						mode_n           = i2cdf_pkg::MODE_CMD;
						id_n             = ID_CLEAR;
						idcnt_n          = 3'd0;
						cnt_n            = '0;
						ovf_n            = 1'b0;
						skip_n           = !eot;
						term             = 1'b1;
					end else if (chr == i2cdf_pkg::CHR_LF) begin
						// partial message, continues next transfer
						skip_n = !eot;
						term   = 1'b1;
					end else if (cnt_q < CNT_W'(MSG_CAPACITY)) begin
						res.data_valid = 1'b1;
						res.data_byte  = chr;
						res.byte_index = cnt_ext[7:0];
						res.overflow   = ovf_q;
						cnt_n          = cnt_q + CNT_W'(1);
						emit           = 1'b1;
					end else begin
						ovf_n = 1'b1;
					end
				end
				default: begin
					// unsynchronized: only a NUL restarts ID reception
					mode_n = i2cdf_pkg::MODE_UNSYNC;
					if (chr == i2cdf_pkg::CHR_NUL) begin
						mode_n  = i2cdf_pkg::MODE_CMD;
						id_n    = ID_CLEAR;
						idcnt_n = 3'd0;
						cnt_n   = '0;
						ovf_n   = 1'b0;
						term    = 1'b1;
					end
				end
			endcase

			// transfer ended without a terminator
			if (!long_id && eot && !term) begin
				mode_n  = i2cdf_pkg::MODE_UNSYNC;
				id_n    = ID_CLEAR;
				idcnt_n = 3'd0;
				if (mode_q != i2cdf_pkg::MODE_UNSYNC) begin
					res.sync_lost = 1'b1;
					res.overflow  = ovf_n;
					emit          = 1'b1;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= i2cdf_pkg::MODE_CMD;
			skip_q  <= 1'b0;
			idcnt_q <= 3'd0;
			id_q    <= ID_CLEAR;
			held_q  <= 16'd0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_n;
			skip_q  <= skip_n;
			idcnt_q <= idcnt_n;
			id_q    <= id_n;
			held_q  <= held_n;
			cnt_q   <= cnt_n;
			ovf_q   <= ovf_n;
		end
	end

endmodule

// ===== design/i2c_id_message_deframer_unit.sv =====
// I2C ID message deframer: received bytes are parsed into an ID (up to CR)
// and indexed payload bytes (up to NUL). The block takes one byte per clock
// while the input is not stalled: a byte sits in the input register, the
// framing state is updated in a single step, and any result lands in the
// output register. A byte that produces no result never waits
// for the output side; a byte that produces one waits only while the output
// register holds an untaken result, and then stalls the input until it moves.
module i2c_id_message_deframer_unit #(
	parameter int MSG_CAPACITY = i2cdf_pkg::MSG_CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               end_of_transfer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               data_valid,
	output logic [7:0]         data_byte,
	output logic [7:0]         byte_index,
	output logic               message_done,
	output logic signed [15:0] message_id,
	output logic               overflow,
	output logic               sync_lost
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eot_s1;
	logic            out_ready;
	logic            emit;
	logic            step;
	i2cdf_pkg::res_t res;
	i2cdf_pkg::res_t res_q;
	logic            out_valid_q;

	i2cdf_frame #(
		.MSG_CAPACITY (MSG_CAPACITY)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.chr    (byte_s1),
		.eot    (eot_s1),
		.emit   (emit),
		.res    (res)
	);

	// Flow control
	assign out_ready = !out_valid_q || !out_stall;
	assign step      = valid_s1 && (out_ready || !emit);
	assign in_stall  = valid_s1 && !step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
			eot_s1  <= end_of_transfer;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_valid   = res_q.data_valid;
	assign data_byte    = res_q.data_byte;
	assign byte_index   = res_q.byte_index;
	assign message_done = res_q.message_done;
	assign message_id   = res_q.message_id;
	assign overflow     = res_q.overflow;
	assign sync_lost    = res_q.sync_lost;

	// Checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_result_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (data_valid || message_done || sync_lost))
		else $error("result carries no event");

	a_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(message_done && (data_valid || sync_lost)))
		else $error("message end mixed with data or sync loss");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_q))
		else $error("stalled result changed");

endmodule

// ===== sim/tb_i2c_id_message_deframer_unit.sv =====
// Testbench for the I2C ID message deframer: random and directed byte streams.
module tb_i2c_id_message_deframer_unit;

	localparam int MSG_CAP      = i2cdf_pkg::MSG_CAPACITY_DEF;
	localparam int HOLD_CYCLES  = 60;
	localparam int WATCHDOG_MAX = 3000;
	localparam int DRAIN_CYCLES = 8;

	// One byte request as offered to the block
	typedef struct {
		logic [7:0] b;
		logic       e;
	} rx_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               end_of_transfer = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               data_valid;
	logic [7:0]         data_byte;
	logic [7:0]         byte_index;
	logic               message_done;
	logic signed [15:0] message_id;
	logic               overflow;
	logic               sync_lost;

	rx_req_t          rx_queue[$];
	i2cdf_pkg::res_t  predicted_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int fail_count = 0;
	int n_bytes = 0;
	int n_results = 0;
	int n_done = 0;
	int n_sync = 0;
	int n_ovf = 0;
	int n_queued = 0;
	int idle_cycles = 0;

	// Predictor state
	i2cdf_pkg::mode_t  st_mode = i2cdf_pkg::MODE_CMD;
	bit                st_skip = 1'b0;
	logic [2:0]        st_id_chars = 3'd0;
	i2cdf_pkg::phase_t st_phase = i2cdf_pkg::PH_SPACE;
	bit                st_neg = 1'b0;
	logic [15:0]       st_acc = 16'd0;
	logic [15:0]       st_held = 16'd0;
	logic [8:0]        st_count = 9'd0;
	bit                st_ovf = 1'b0;

	i2c_id_message_deframer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.end_of_transfer(end_of_transfer),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_valid(data_valid),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.message_done(message_done),
		.message_id(message_id),
		.overflow(overflow),
		.sync_lost(sync_lost)
	);

	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic void clear_id_parse();
		st_id_chars = 3'd0;
		st_phase = i2cdf_pkg::PH_SPACE;
		st_neg = 1'b0;
		st_acc = 16'd0;
	endfunction

	function automatic void start_command();
		st_mode = i2cdf_pkg::MODE_CMD;
		clear_id_parse();
		st_count = 9'd0;
		st_ovf = 1'b0;
	endfunction

	// Advance the framing state by one byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [7:0] c, input logic eot,
			output i2cdf_pkg::res_t r);
		bit term;
		bit was_unsync;
		bit digit;
		bit emit;
		r = '0;
		term = 1'b0;
		emit = 1'b0;
		was_unsync = (st_mode == i2cdf_pkg::MODE_UNSYNC);
		digit = (c >= i2cdf_pkg::CHR_ZERO && c <= i2cdf_pkg::CHR_NINE);

		// rest of transfer is dropped
		if (st_skip) begin
			if (eot)
				st_skip = 1'b0;
			return 1'b0;
		end

		case (st_mode)
			i2cdf_pkg::MODE_CMD: begin
				if (c == i2cdf_pkg::CHR_CR) begin
					st_held = st_neg ? (16'd0 - st_acc) : st_acc;
					st_mode = i2cdf_pkg::MODE_DATA;
					st_count = 9'd0;
					st_ovf = 1'b0;
				end else if (st_id_chars >= i2cdf_pkg::ID_MAX_CHARS) begin
					// ID too long
					st_mode = i2cdf_pkg::MODE_UNSYNC;
					clear_id_parse();
					st_count = 9'd0;
					st_skip = !eot;
					r.sync_lost = 1'b1;
					r.overflow = st_ovf;
					return 1'b1;
				end else begin
					// atoi: whitespace, optional sign, digits
					if (st_phase == i2cdf_pkg::PH_SPACE) begin
						if (c == i2cdf_pkg::CHR_SP ||
							(c >= i2cdf_pkg::CHR_TAB && c <= i2cdf_pkg::CHR_FF)) begin
						end else if (c == i2cdf_pkg::CHR_PLUS ||
							c == i2cdf_pkg::CHR_MINUS) begin
							st_neg = (c == i2cdf_pkg::CHR_MINUS);
							st_phase = i2cdf_pkg::PH_DIGITS;
						end else if (digit) begin
							st_phase = i2cdf_pkg::PH_DIGITS;
							st_acc = st_acc * 16'd10 + {8'd0, c - i2cdf_pkg::CHR_ZERO};
						end else begin
							st_phase = i2cdf_pkg::PH_DONE;
						end
					end else if (st_phase == i2cdf_pkg::PH_DIGITS) begin
						if (digit)
							st_acc = st_acc * 16'd10 + {8'd0, c - i2cdf_pkg::CHR_ZERO};
						else
							st_phase = i2cdf_pkg::PH_DONE;
					end
					st_id_chars = st_id_chars + 3'd1;
				end
			end
			i2cdf_pkg::MODE_DATA: begin
				if (c == i2cdf_pkg::CHR_NUL) begin
					r.byte_index = st_count[7:0];
					r.message_done = 1'b1;
					r.message_id = st_held;
					r.overflow = st_ovf;
					emit = 1'b1;
					start_command();
					st_skip = !eot;
					term = 1'b1;
				end else if (c == i2cdf_pkg::CHR_LF) begin
					st_skip = !eot;
					term = 1'b1;
				end else if (int'(st_count) < MSG_CAP) begin
					r.data_valid = 1'b1;
					r.data_byte = c;
					r.byte_index = st_count[7:0];
					st_count = st_count + 9'd1;
					r.overflow = st_ovf;
					emit = 1'b1;
				end else begin
					st_ovf = 1'b1;
				end
			end
			default: begin
				st_mode = i2cdf_pkg::MODE_UNSYNC;
				if (c == i2cdf_pkg::CHR_NUL) begin
					start_command();
					term = 1'b1;
				end
			end
		endcase

		// transfer ended without a terminator
		if (eot && !term) begin
			st_mode = i2cdf_pkg::MODE_UNSYNC;
			clear_id_parse();
			if (!was_unsync) begin
				r.sync_lost = 1'b1;
				r.overflow = st_ovf;
				emit = 1'b1;
			end
		end
		return emit;
	endfunction

	// ---------------- stimulus helpers ----------------

	task automatic send(input logic [7:0] b, input logic e);
		rx_queue.push_back('{b, e});
		n_queued++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	// random bytes up to the end of the transfer (skipped by the block)
	task automatic send_tail();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			send(8'($urandom_range(255)), i == n - 1);
	endtask

	// mostly digits, some whitespace, signs and arbitrary bytes
	task automatic send_id_field();
		int n;
		int pick;
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send(8'(i2cdf_pkg::CHR_ZERO + $urandom_range(9)), 1'b0);
			else if (pick < 83)
				send(pick[0] ? i2cdf_pkg::CHR_SP :
					8'(i2cdf_pkg::CHR_TAB + $urandom_range(3)), 1'b0);
			else if (pick < 91)
				send(pick[0] ? i2cdf_pkg::CHR_MINUS : i2cdf_pkg::CHR_PLUS, 1'b0);
			else
				send(8'($urandom_range(255)), 1'b0);
		end
	endtask

	// payload bytes, no NUL or LF; CR shows up as plain data
	task automatic send_payload(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(1, 255));
			if (b == i2cdf_pkg::CHR_LF)
				b = i2cdf_pkg::CHR_CR;
			send(b, 1'b0);
		end
	endtask

	// ID, CR, payload (maybe split by LF across transfers), NUL
	task automatic send_message(input int len);
		int part;
		send_id_field();
		send(i2cdf_pkg::CHR_CR, 1'b0);
		if (len > 0 && $urandom_range(99) < 15) begin
			part = $urandom_range(0, len);
			send_payload(part);
			if ($urandom_range(3) == 0) begin
				send(i2cdf_pkg::CHR_LF, 1'b0);
				send_tail();
			end else begin
				send(i2cdf_pkg::CHR_LF, 1'b1);
			end
			send_payload(len - part);
		end else begin
			send_payload(len);
		end
		if ($urandom_range(99) < 15) begin
			send(i2cdf_pkg::CHR_NUL, 1'b0);
			send_tail();
		end else begin
			send(i2cdf_pkg::CHR_NUL, 1'b1);
		end
	endtask

	// one random transfer: mostly well formed, some broken, some noise
	task automatic send_transfer();
		int k;
		int n;
		logic [7:0] b;
		k = $urandom_range(99);
		if (k < 70) begin
			send_message($urandom_range(0, 10));
		end else begin
			if (k < 78) begin
				// ID past the length limit
				n = $urandom_range(7, 9);
				for (int i = 0; i < n; i++)
					send(8'(i2cdf_pkg::CHR_ZERO + $urandom_range(9)), i == n - 1);
			end else if (k < 86) begin
				// transfer cut short inside the payload
				send_id_field();
				send(i2cdf_pkg::CHR_CR, 1'b0);
				send_payload($urandom_range(0, 4));
				b = 8'($urandom_range(1, 255));
				if (b == i2cdf_pkg::CHR_LF)
					b = i2cdf_pkg::CHR_CR;
				send(b, 1'b1);
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send(8'($urandom_range(255)), ($urandom_range(3) == 0) || (i == n - 1));
			end
			// NUL first in a transfer to get back in sync
			if ($urandom_range(99) < 70) begin
				send(i2cdf_pkg::CHR_NUL, 1'b0);
				send_message($urandom_range(0, 6));
			end
		end
	endtask

	// mark the most recently queued byte as the end of its transfer
	task automatic end_last_eot();
		rx_queue[rx_queue.size() - 1].e = 1'b1;
	endtask

	// ---------------- driver ----------------

	always @(posedge clk) begin : rx_driver
		i2cdf_pkg::res_t r;
		rx_req_t req;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				n_bytes++;
				if (deframe_byte(rx_byte, end_of_transfer, r))
					predicted_results.push_back(r);
			end
			if (!in_valid || !in_stall) begin
				if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req = rx_queue.pop_front();
					in_valid <= 1'b1;
					rx_byte <= req.b;
					end_of_transfer <= req.e;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------

	task automatic check_field(input string name, input logic signed [31:0] exp_v,
			input logic signed [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		i2cdf_pkg::res_t e;
		if (arst_n) begin
			if (out_valid === 1'b1 && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$error("result with nothing expected: data_byte %0d sync_lost %0d",
						data_byte, sync_lost);
					fail_count++;
				end else begin
					e = predicted_results.pop_front();
					n_results++;
					n_done += int'(e.message_done);
					n_sync += int'(e.sync_lost);
					n_ovf += int'(e.message_done & e.overflow);
					check_field("data_valid", 32'(e.data_valid), 32'(data_valid));
					check_field("data_byte", 32'(e.data_byte), 32'(data_byte));
					check_field("byte_index", 32'(e.byte_index), 32'(byte_index));
					check_field("message_done", 32'(e.message_done), 32'(message_done));
					check_field("message_id", 32'(e.message_id), 32'(message_id));
					check_field("overflow", 32'(e.overflow), 32'(overflow));
					check_field("sync_lost", 32'(e.sync_lost), 32'(sync_lost));
				end
			end
			// long hold-off on request, otherwise random stalls
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$error("no request accepted for %0d cycles", WATCHDOG_MAX);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	task automatic wait_drained();
		while (rx_queue.size() != 0 || in_valid || predicted_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Phase 0: sender idles a little, receiver a lot
		send_idle_pct = 19;
		recv_idle_pct = 88;

		// whitespace, sign, NUL ending the ID digits, payload extremes
		send(i2cdf_pkg::CHR_TAB, 1'b0);
		send_str("-7");
		send(i2cdf_pkg::CHR_NUL, 1'b0);
		send_str("8");
		send(i2cdf_pkg::CHR_CR, 1'b0);
		send(8'h01, 1'b0);
		send(8'hFF, 1'b0);
		send(i2cdf_pkg::CHR_NUL, 1'b1);
		// CR as data, LF splits the message over two transfers
		send_str("+5");
		send(i2cdf_pkg::CHR_CR, 1'b0);
		send(i2cdf_pkg::CHR_CR, 1'b0);
		send(i2cdf_pkg::CHR_LF, 1'b1);
		send_str("Z");
		send(i2cdf_pkg::CHR_NUL, 1'b1);
		// ID too long, rest of transfer skipped
		send_str("1234567");
		send_str("8");
		end_last_eot();
		// NUL while out of sync restarts, same transfer parsed
		send(i2cdf_pkg::CHR_NUL, 1'b0);
		send_str("3");
		send(i2cdf_pkg::CHR_CR, 1'b0);
		send(i2cdf_pkg::CHR_NUL, 1'b1);
		// transfer without terminator, then a lone NUL resyncs
		send(8'(i2cdf_pkg::CHR_ZERO + 8'd4), 1'b1);
		send(i2cdf_pkg::CHR_NUL, 1'b1);

		while (n_queued < 220)
			send_transfer();
		wait_drained();

		// Phase 1: the other way round
		send_idle_pct = 88;
		recv_idle_pct = 19;
		while (n_queued < 420)
			send_transfer();
		wait_drained();

		// Phase 2: no idling; long receiver hold-off while the sender keeps going
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_ask++;
		while (n_queued < 470)
			send_transfer();
		// one message past capacity
		send_message($urandom_range(MSG_CAP + 1, MSG_CAP + 6));
		while (n_queued < 800)
			send_transfer();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d bytes and %0d results: %0d completed messages, %0d sync losses,",
			n_bytes, n_results, n_done, n_sync);
		$display("  %0d messages with overflow, under three sender/receiver idle mixes", n_ovf);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/i2cdf_pkg.sv
design/i2cdf_id_parse.sv
design/i2cdf_frame.sv
design/i2c_id_message_deframer_unit.sv
sim/tb_i2c_id_message_deframer_unit.sv
